@@ src/mts_pkg.sv @@
// Shared types, codes and name tables for the metadata tag scanner.
// No dependencies; used by mts_step and opf_metadata_tag_scanner_core.
package mts_pkg;

    localparam int MAX_TEXT_BYTES = 65536;

    // Highest byte offset that the position counters reach for a given text size.
    function automatic logic [15:0] pos_limit(input int max_bytes);
        return (max_bytes - 1 > 65535) ? 16'hFFFF : 16'(max_bytes - 1);
    endfunction

    localparam logic [15:0] TOP_OFFSET = pos_limit(MAX_TEXT_BYTES);

    localparam logic [1:0] SEC_OUT  = 2'd0;
    localparam logic [1:0] SEC_IN   = 2'd1;
    localparam logic [1:0] SEC_DONE = 2'd2;

    localparam logic [2:0] PH_TEXT  = 3'd0;
    localparam logic [2:0] PH_OPEN  = 3'd1;
    localparam logic [2:0] PH_NAME  = 3'd2;
    localparam logic [2:0] PH_ATTR  = 3'd3;
    localparam logic [2:0] PH_INNER = 3'd4;
    localparam logic [2:0] PH_CLOSE = 3'd5;

    localparam logic [2:0] KIND_CREATOR  = 3'd0;
    localparam logic [2:0] KIND_TITLE    = 3'd1;
    localparam logic [2:0] KIND_LANGUAGE = 3'd2;
    localparam logic [2:0] KIND_OK       = 3'd3;
    localparam logic [2:0] KIND_FAIL     = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // Names are stored first character in the top byte, zero filled to 16 bytes.
    localparam logic [127:0] NAME_METADATA = {"metadata", 64'h0};
    localparam logic [127:0] NAME_CREATOR  = {"dc:creator", 48'h0};
    localparam logic [127:0] NAME_TITLE    = {"dc:title", 64'h0};
    localparam logic [127:0] NAME_LANGUAGE = {"dc:language", 40'h0};

    localparam logic [3:0] NAME_LEN [4] = '{4'd8, 4'd10, 4'd8, 4'd11};

    typedef struct packed {
        logic [1:0]  section;
        logic [2:0]  phase;
        logic [15:0] pos;
        logic [3:0]  name_len;
        logic [3:0]  flags;
        logic [15:0] span_start;
        logic [15:0] span_len;
    } t_scan_state;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [15:0] text_start;
        logic [15:0] text_len;
    } t_scan_result;

    // Character of name k at index idx; zero past the end of the name.
    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [3:0] idx);
        logic [127:0] s;
        logic [6:0]   base;
        begin
            unique case (k)
                2'd0:    s = NAME_METADATA;
                2'd1:    s = NAME_CREATOR;
                2'd2:    s = NAME_TITLE;
                default: s = NAME_LANGUAGE;
            endcase
            base = {~idx, 3'b000};
            name_char = s[base +: 8];
        end
    endfunction

endpackage

@@ src/mts_step.sv @@
// Next-state and result logic for one text byte of the metadata tag scanner.
// Depends on mts_pkg.
module mts_step #(
    parameter int MAX_TEXT_BYTES = mts_pkg::MAX_TEXT_BYTES
) (
    input  mts_pkg::t_scan_state  i_state,
    input  logic [7:0]            i_ch,
    output mts_pkg::t_scan_state  o_state,
    output mts_pkg::t_scan_result o_result
);
    import mts_pkg::*;

    localparam logic [15:0] POS_LIMIT = pos_limit(MAX_TEXT_BYTES);

    logic        is_delim;
    logic        from_open;
    logic [3:0]  base_len;
    logic [3:0]  base_flags;
    logic [3:0]  add_flags;
    logic [3:0]  add_len;
    logic [3:0]  fin_flags;
    logic [15:0] pos_next;
    logic [15:0] inner_first;

    always_comb begin
        is_delim  = (i_ch == CH_SPACE) || (i_ch == CH_GT);
        // The byte after '<' inside the section starts a fresh name.
        from_open  = (i_state.section == SEC_IN) && (i_state.phase == PH_OPEN);
        base_len   = from_open ? 4'd0 : i_state.name_len;
        base_flags = from_open ? 4'hF : i_state.flags;
        for (int k = 0; k < 4; k++) begin
            add_flags[k] = base_flags[k] && (name_char(2'(k), base_len) == i_ch);
            fin_flags[k] = base_flags[k] && (base_len == NAME_LEN[k]);
        end
        add_len     = (base_len == 4'hF) ? 4'hF : base_len + 4'd1;
        pos_next    = (i_state.pos < POS_LIMIT) ? i_state.pos + 16'd1 : POS_LIMIT;
        inner_first = pos_next;
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.section == SEC_OUT || i_state.section == SEC_IN) begin
            if (i_ch == CH_NUL) begin
                o_result.valid = 1'b1;
                o_result.kind  = KIND_FAIL;
                o_state.section = SEC_DONE;
            end else begin
                o_state.pos = pos_next;
                if (i_state.section == SEC_OUT) begin
                    if (i_ch == CH_LT) begin
                        o_state.name_len = 4'd0;
                        o_state.flags    = 4'hF;
                        o_state.phase    = PH_NAME;
                    end else if (i_state.phase == PH_NAME) begin
                        if (is_delim) begin
                            o_state.flags = fin_flags;
                            if (fin_flags[0]) begin
                                o_state.section = SEC_IN;
                            end
                            o_state.phase = PH_TEXT;
                        end else begin
                            o_state.flags    = add_flags;
                            o_state.name_len = add_len;
                        end
                    end else begin
                        o_state.phase = PH_TEXT;
                    end
                end else begin
                    unique case (i_state.phase) inside
                        PH_OPEN, PH_NAME: begin
                            if (from_open && i_ch == CH_SLASH) begin
                                o_result.valid  = 1'b1;
                                o_result.kind   = KIND_OK;
                                o_state.section = SEC_DONE;
                                o_state.pos     = i_state.pos;
                            end else if (from_open && (i_ch == CH_BANG || i_ch == CH_QUEST)) begin
                                o_state.phase = PH_TEXT;
                            end else if (is_delim) begin
                                o_state.name_len = base_len;
                                o_state.flags    = fin_flags;
                                if (i_ch == CH_GT) begin
                                    o_state.span_start = inner_first;
                                    o_state.span_len   = 16'd0;
                                    o_state.phase      = PH_INNER;
                                end else begin
                                    o_state.phase = PH_ATTR;
                                end
                            end else begin
                                o_state.flags    = add_flags;
                                o_state.name_len = add_len;
                                o_state.phase    = PH_NAME;
                            end
                        end
                        PH_ATTR: begin
                            if (i_ch == CH_GT) begin
                                o_state.span_start = inner_first;
                                o_state.span_len   = 16'd0;
                                o_state.phase      = PH_INNER;
                            end
                        end
                        PH_INNER: begin
                            if (i_ch == CH_LT) begin
                                o_state.phase = PH_CLOSE;
                            end else if (i_state.span_len != 16'hFFFF) begin
                                o_state.span_len = i_state.span_len + 16'd1;
                            end
                        end
                        PH_CLOSE: begin
                            if (i_ch == CH_GT) begin
                                o_result.text_start = i_state.span_start;
                                o_result.text_len   = i_state.span_len;
                                if (i_state.flags[1]) begin
                                    o_result.valid = 1'b1;
                                    o_result.kind  = KIND_CREATOR;
                                end else if (i_state.flags[2]) begin
                                    o_result.valid = 1'b1;
                                    o_result.kind  = KIND_TITLE;
                                end else if (i_state.flags[3]) begin
                                    o_result.valid = 1'b1;
                                    o_result.kind  = KIND_LANGUAGE;
                                end
                                o_state.phase = PH_TEXT;
                            end
                        end
                        default: begin
                            o_state.phase = (i_ch == CH_LT) ? PH_OPEN : PH_TEXT;
                        end
                    endcase
                end
            end
        end
    end

endmodule

@@ src/opf_metadata_tag_scanner_core.sv @@
// Top level of the metadata tag scanner: stream ports, input and result registers.
// Depends on mts_pkg and mts_step.

// The scanner takes one text byte per beat and can accept a byte in every cycle;
// a result is offered once its byte has been parsed by a single pass of logic
// between the input register and the result register and stored there. A result
// held by the sink stalls the input once the input register is also occupied.
// A byte of value zero ends the text with a done-fail result; a closing tag in the
// metadata section ends it with done-ok. After either, bytes are accepted and
// dropped until reset. Span results carry the inner text offset and length.
module opf_metadata_tag_scanner_core #(
    parameter int MAX_TEXT_BYTES = mts_pkg::MAX_TEXT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] text_start, [31:16] text_len
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import mts_pkg::*;

    localparam logic [15:0] POS_LIMIT = pos_limit(MAX_TEXT_BYTES);

    logic         r_in_valid;
    logic [7:0]   r_ch;
    t_scan_state  r_state;
    logic         r_out_valid;
    logic [2:0]   r_kind;
    logic [15:0]  r_start;
    logic [15:0]  r_len;

    t_scan_state  n_state;
    t_scan_result step_res;
    logic         advance;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    mts_step #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .o_state  (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{section: SEC_OUT, phase: PH_TEXT, pos: 16'd0, name_len: 4'd0,
                             flags: 4'hF, span_start: 16'd0, span_len: 16'd0};
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && step_res.valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_ch <= s_axis_tdata;
        end
        if (advance && r_in_valid && step_res.valid) begin
            r_kind  <= step_res.kind;
            r_start <= step_res.text_start;
            r_len   <= step_res.text_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_len, r_start};
    assign m_axis_tuser  = r_kind;

    // Once the scan has finished, it stays finished until reset.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.section == SEC_DONE |=> r_state.section == SEC_DONE)
        else $error("scanner left the finished state");

    // A done result is only shown after the scan state has been marked finished.
    a_done_marks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_OK || m_axis_tuser == KIND_FAIL)
        |-> r_state.section == SEC_DONE)
        else $error("done result without finished scan state");

    // The byte offset never runs past the top offset.
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= POS_LIMIT)
        else $error("byte position beyond top offset");

    // A result waiting at the output is held while the sink stalls.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

@@ bench/opf_metadata_tag_scanner_core_test.sv @@
// Self-checking bench for the metadata tag scanner: it feeds one document byte by byte and
// checks every span and end report against an in-bench model of the scanner.
// Depends on mts_pkg and opf_metadata_tag_scanner_core.
`timescale 1ns / 1ps

module opf_metadata_tag_scanner_core_test;
    import mts_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] text_start;
        logic [15:0] text_len;
    } t_span_report;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [15:0] text_start, [31:16] text_len
    logic [2:0]  m_axis_tuser;           // [2:0] kind

    opf_metadata_tag_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Scanner state as the bench predicts it.
    logic [1:0]  sc_section    = SEC_OUT;
    logic [2:0]  sc_phase      = PH_TEXT;
    logic [15:0] sc_pos        = 16'd0;
    logic [3:0]  sc_name_len   = 4'd0;
    logic [3:0]  sc_flags      = 4'hF;
    logic [15:0] sc_span_start = 16'd0;
    logic [15:0] sc_span_len   = 16'd0;

    string tag_text [4] = '{"metadata", "dc:creator", "dc:title", "dc:language"};

    t_span_report pending_reports [$];
    t_span_report head_report;
    int           mismatch_count = 0;
    int           bytes_sent = 0;
    int           cycle_count = 0;
    int           hold_left = 0;
    int           stall_left = 0;
    bit           idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    task automatic expect_report(input logic [2:0] kind, input logic [15:0] start,
                                 input logic [15:0] length);
        t_span_report r;
        r.kind = kind;
        r.text_start = start;
        r.text_len = length;
        pending_reports.push_back(r);
    endtask

    task automatic add_name_byte(input logic [7:0] b);
        for (int k = 0; k < 4; k++) begin
            if (sc_name_len >= tag_text[k].len() || tag_text[k][sc_name_len] != b)
                sc_flags[k] = 1'b0;
        end
        if (sc_name_len < 4'd15) sc_name_len++;
    endtask

    task automatic close_name();
        for (int k = 0; k < 4; k++) begin
            if (sc_name_len != tag_text[k].len()) sc_flags[k] = 1'b0;
        end
    endtask

    task automatic begin_inner();
        sc_span_start = (sc_pos < TOP_OFFSET) ? sc_pos + 16'd1 : TOP_OFFSET;
        sc_span_len = 16'd0;
        sc_phase = PH_INNER;
    endtask

    task automatic name_byte_in_section(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_GT) begin
            close_name();
            if (b == CH_GT) begin_inner();
            else sc_phase = PH_ATTR;
        end else begin
            add_name_byte(b);
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        logic [2:0] ph;
        ph = sc_phase;
        if (sc_section >= SEC_DONE) return;
        if (b == CH_NUL) begin
            expect_report(KIND_FAIL, 16'd0, 16'd0);
            sc_section = SEC_DONE;
            return;
        end
        if (sc_section == SEC_OUT) begin
            if (b == CH_LT) begin
                sc_name_len = 4'd0;
                sc_flags = 4'hF;
                sc_phase = PH_NAME;
            end else if (ph == PH_NAME) begin
                if (b == CH_SPACE || b == CH_GT) begin
                    close_name();
                    if (sc_flags[0]) sc_section = SEC_IN;
                    sc_phase = PH_TEXT;
                end else begin
                    add_name_byte(b);
                end
            end else begin
                sc_phase = PH_TEXT;
            end
        end else begin
            case (ph)
                PH_OPEN: begin
                    if (b == CH_SLASH) begin
                        expect_report(KIND_OK, 16'd0, 16'd0);
                        sc_section = SEC_DONE;
                        return;
                    end else if (b == CH_BANG || b == CH_QUEST) begin
                        sc_phase = PH_TEXT;
                    end else begin
                        sc_name_len = 4'd0;
                        sc_flags = 4'hF;
                        sc_phase = PH_NAME;
                        name_byte_in_section(b);
                    end
                end
                PH_NAME: name_byte_in_section(b);
                PH_ATTR: begin
                    if (b == CH_GT) begin_inner();
                end
                PH_INNER: begin
                    if (b == CH_LT) sc_phase = PH_CLOSE;
                    else if (sc_span_len != 16'hFFFF) sc_span_len++;
                end
                PH_CLOSE: begin
                    if (b == CH_GT) begin
                        // Creator wins over title, title over language.
                        if (sc_flags[1]) expect_report(KIND_CREATOR, sc_span_start, sc_span_len);
                        else if (sc_flags[2]) expect_report(KIND_TITLE, sc_span_start, sc_span_len);
                        else if (sc_flags[3])
                            expect_report(KIND_LANGUAGE, sc_span_start, sc_span_len);
                        sc_phase = PH_TEXT;
                    end
                end
                default: sc_phase = (b == CH_LT) ? PH_OPEN : PH_TEXT;
            endcase
        end
        if (sc_pos < TOP_OFFSET) sc_pos++;
    endtask

    // True when this byte would end the document in the current state.
    function automatic bit would_end(input logic [7:0] b);
        return b == CH_NUL || (sc_section == SEC_IN && sc_phase == PH_OPEN && b == CH_SLASH);
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result: kind %0d", m_axis_tuser);
                mismatch_count++;
            end else begin
                head_report = pending_reports.pop_front();
                if (m_axis_tuser !== head_report.kind) begin
                    $error("kind: expected %0d, got %0d", head_report.kind, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:0] !== head_report.text_start) begin
                    $error("text_start: expected %0d, got %0d",
                           head_report.text_start, m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[31:16] !== head_report.text_len) begin
                    $error("text_len: expected %0d, got %0d",
                           head_report.text_len, m_axis_tdata[31:16]);
                    mismatch_count++;
                end
            end
        end
    end

    // Result side: random stall bursts, plus long holds requested by the tests.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        scan_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Sends a byte, swapped for a harmless one if it would end the document.
    task automatic put(input logic [7:0] b);
        if (would_end(b)) b = "x";
        send_byte(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_random(input int count, input logic [7:0] stop_a,
                              input logic [7:0] stop_b);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            do b = 8'($urandom_range(1, 255)); while (b == stop_a || b == stop_b);
            put(b);
        end
    endtask

    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_outside_section();
        // Near misses, empty names, an overlong name and a title that does not count yet.
        put_str("ab<<metadat<meta>x<>< metadata><metadataxyzmetadataxyz>");
        put_str("<dc:title>no</dc:title></metadata>");
        // A '<' inside a name restarts it; the section opens at the space.
        put_str("<q<metadata xmlns='m'>");
    endtask

    task automatic test_directed_spans();
        put_str("<dc:creator>Ann</dc:creator>");
        put_str("<dc:title id='1'>T</dc:title>");
        put_str("<dc:language></dc:language>");
        put_str("<!-- c --><?pi x?>");
        put_str("<>e</>< a>e<x>");
        put_str("<dc:title<b>q</dc:title><dc:titles>q</dc:titles>");
    endtask

    task automatic send_element();
        string nm;
        bit    rand_name;
        int    pick;
        int    k;
        rand_name = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            case ($urandom_range(0, 7))
                0, 1: nm = "dc:creator";
                2, 3: nm = "dc:title";
                4: nm = "dc:language";
                5: nm = "metadata";
                6: begin
                    k = $urandom_range(1, 3);
                    if ($urandom_range(0, 1)) nm = tag_text[k].substr(0, tag_text[k].len() - 2);
                    else nm = {tag_text[k], "s"};
                end
                default: begin
                    nm = "";
                    rand_name = 1'b1;
                end
            endcase
            put(CH_LT);
            if (rand_name) put_random($urandom_range(1, 18), CH_SPACE, CH_GT);
            else put_str(nm);
            if ($urandom_range(0, 3) == 0) begin
                put(CH_SPACE);
                put_random($urandom_range(0, 10), CH_GT, CH_GT);
            end
            put(CH_GT);
            if ($urandom_range(0, 9) == 0) put_random($urandom_range(20, 80), CH_LT, CH_LT);
            else put_random($urandom_range(0, 8), CH_LT, CH_LT);
            put(CH_LT);
            if ($urandom_range(0, 3) != 0) begin
                put(CH_SLASH);
                put_str(nm);
            end else begin
                put_random($urandom_range(0, 6), CH_GT, CH_GT);
            end
            put(CH_GT);
        end else if (pick < 80) begin
            put_random($urandom_range(1, 8), CH_LT, CH_LT);
        end else if (pick < 88) begin
            put(CH_LT);
            put($urandom_range(0, 1) ? CH_BANG : CH_QUEST);
            put_random($urandom_range(0, 10), CH_LT, CH_LT);
            put(CH_GT);
        end else begin
            // Broken markup: random bytes that do not end the document, which may leave a tag half open.
            put_random($urandom_range(1, 15), CH_NUL, CH_NUL);
        end
    endtask

    task automatic test_random_document();
        int target;
        target = bytes_sent + 300;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
            send_element();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        repeat (10) put_str("<dc:title>ab</dc:title>");
        wait_for_reports();
    endtask

    // A long inner text, followed by a short span.
    task automatic test_long_inner_text();
        put_str("<dc:language>");
        put_random(60, CH_LT, CH_LT);
        put_str("</x>");
        put_str("<dc:creator>z</dc:creator>");
    endtask

    task automatic test_end_of_document();
        case ($urandom_range(0, 2))
            0: begin
                send_byte(CH_LT);
                send_byte(CH_SLASH);
                put_str("metadata>");
            end
            1: send_byte(CH_NUL);
            default: begin
                // End of text in the middle of an inner text.
                put_str("<dc:title>ab");
                send_byte(CH_NUL);
            end
        endcase
        // Everything after the end is dropped.
        put_str("<dc:title>zz</dc:title>");
        send_byte(CH_NUL);
        send_byte(CH_LT);
        send_byte(CH_SLASH);
        put_random(20, CH_NUL, CH_NUL);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_outside_section();
        test_directed_spans();
        test_random_document();
        test_backpressure();
        idle_on = 1'b0;
        test_long_inner_text();
        test_end_of_document();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
